@@ rtl/core/srt_pkg.sv @@
`default_nettype none

package srt_pkg;

    localparam int PID_W      = 8;
    localparam int BURST_W    = 16;
    localparam int STATUS_W   = 3;
    localparam int OUT_TIME_W = 32;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [STATUS_W-1:0] ST_RAN    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_IDLE   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DONE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_ACCEPT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REJECT = 3'd4;

endpackage

`default_nettype wire

@@ rtl/core/srt_item_if.sv @@
`default_nettype none

interface srt_item_if
    import srt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [PID_W-1:0]   proc_id;
    logic [BURST_W-1:0] burst_len;

    modport source (output valid, output operation, output proc_id, output burst_len,
                    input ready);
    modport sink   (input valid, input operation, input proc_id, input burst_len,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/srt_result_if.sv @@
`default_nettype none

interface srt_result_if
    import srt_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [PID_W-1:0]      run_id;
    logic [OUT_TIME_W-1:0] finish_time;
    logic [OUT_TIME_W-1:0] turnaround;
    logic [OUT_TIME_W-1:0] waiting;

    modport source (output valid, output status, output run_id, output finish_time,
                    output turnaround, output waiting, input ready);
    modport sink   (input valid, input status, input run_id, input finish_time,
                    input turnaround, input waiting, output ready);
endinterface

`default_nettype wire

@@ rtl/core/srt_table.sv @@
`default_nettype none

module srt_table #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 72
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/shortest_remaining_time_scheduler.sv @@
// Shortest-remaining-time-first scheduler.
// Input channel "item": operation 0 enters a process (proc_id, burst_len) stamped
// with the current time; operation 1 is one time tick. One result transaction on
// channel "result" per input transaction.
// The process table lives in a one-port-read, one-port-write memory; the valid bits
// sit in flip-flops. A tick reads the table one entry per cycle and keeps the best
// key (remaining, arrival, id), then decrements the chosen entry or frees its slot.
// An arrival searches the valid bits for the lowest free slot, then loads the
// result; a tick scans the table, updates the chosen entry and time, then loads
// the result. The next transaction is taken the cycle after the result is loaded.
// Reset empties the table (valid bits cleared) and zeroes time; there is no
// clearing pass, the block is ready right after reset.
// The result sits in an output register. While the receiver stalls, the next
// transaction is still accepted and worked on; it waits in its last state until
// the output register frees up.
`default_nettype none

module shortest_remaining_time_scheduler
    import srt_pkg::*;
#(
    parameter int MAX_PROCS = 16,
    parameter int TIME_BITS = 32
) (
    input wire logic     clk,
    input wire logic     rst_n,
    srt_item_if.sink     item,
    srt_result_if.source result
);

    localparam int IW = $clog2(MAX_PROCS);
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int XW = TIME_BITS + OUT_TIME_W;
    localparam int EW = PID_W + TIME_BITS + 2 * BURST_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE_SCAN,
        S_ARR_OUT,
        S_SCAN,
        S_TICK_UPD,
        S_TICK_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [PID_W-1:0]      pid_reg, pid_next;
    logic [BURST_W-1:0]    burst_reg, burst_next;
    logic                  found_reg, found_next;
    logic [IW-1:0]         slot_reg, slot_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]         cmp_idx_reg, cmp_idx_next;
    logic                  best_found_reg, best_found_next;
    logic [IW-1:0]         best_idx_reg, best_idx_next;
    logic [BURST_W-1:0]    best_rem_reg, best_rem_next;
    logic [BURST_W-1:0]    best_burst_reg, best_burst_next;
    logic [TIME_BITS-1:0]  best_arr_reg, best_arr_next;
    logic [PID_W-1:0]      best_pid_reg, best_pid_next;
    logic                  done_reg, done_next;
    logic [TIME_BITS-1:0]  tat_reg, tat_next;
    logic [TIME_BITS-1:0]  now_reg, now_next;
    logic [MAX_PROCS-1:0]  valid_reg, valid_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [PID_W-1:0]      out_id_reg, out_id_next;
    logic [OUT_TIME_W-1:0] out_fin_reg, out_fin_next;
    logic [OUT_TIME_W-1:0] out_tat_reg, out_tat_next;
    logic [OUT_TIME_W-1:0] out_wt_reg, out_wt_next;

    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;
    logic [EW-1:0]         mem_wdata;
    logic                  mem_re;
    logic [EW-1:0]         mem_rdata;

    logic [BURST_W-1:0]    rd_rem;
    logic [TIME_BITS-1:0]  rd_arr;
    logic [PID_W-1:0]      rd_pid;
    logic [BURST_W-1:0]    rd_burst;
    logic                  rd_better;
    logic                  slot_free;
    logic                  out_load;
    logic [IW-1:0]         cnt_idx;
    logic [XW-1:0]         now_x;
    logic [XW-1:0]         tat_x;
    logic [XW-1:0]         wt_x;

    srt_table #(
        .DEPTH (MAX_PROCS),
        .WIDTH (EW)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (cnt_idx),
        .rdata (mem_rdata)
    );

    // entry layout: {pid, arrival, burst, remaining}
    assign rd_rem   = mem_rdata[BURST_W-1:0];
    assign rd_burst = mem_rdata[2*BURST_W-1:BURST_W];
    assign rd_arr   = mem_rdata[2*BURST_W+TIME_BITS-1:2*BURST_W];
    assign rd_pid   = mem_rdata[EW-1:EW-PID_W];

    assign rd_better = !best_found_reg ||
                       ({rd_rem, rd_arr, rd_pid} <
                        {best_rem_reg, best_arr_reg, best_pid_reg});

    assign cnt_idx   = cnt_reg[IW-1:0];
    assign slot_free = !out_valid_reg || result.ready;
    assign now_x     = XW'(now_reg);
    assign tat_x     = XW'(tat_reg);
    assign wt_x      = XW'(tat_reg - TIME_BITS'(best_burst_reg));

    assign item.ready         = (state_reg == S_IDLE);
    assign result.valid       = out_valid_reg;
    assign result.status      = out_status_reg;
    assign result.run_id      = out_id_reg;
    assign result.finish_time = out_fin_reg;
    assign result.turnaround  = out_tat_reg;
    assign result.waiting     = out_wt_reg;

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pid_next        = pid_reg;
        burst_next      = burst_reg;
        found_next      = found_reg;
        slot_next       = slot_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_rem_next   = best_rem_reg;
        best_burst_next = best_burst_reg;
        best_arr_next   = best_arr_reg;
        best_pid_next   = best_pid_reg;
        done_next       = done_reg;
        tat_next        = tat_reg;
        now_next        = now_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg && !result.ready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_fin_next    = out_fin_reg;
        out_tat_next    = out_tat_reg;
        out_wt_next     = out_wt_reg;
        out_load        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = best_idx_reg;
        mem_wdata       = {best_pid_reg, best_arr_reg, best_burst_reg,
                           best_rem_reg - BURST_W'(1)};
        mem_re          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    pid_next        = item.proc_id;
                    burst_next      = item.burst_len;
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    best_found_next = 1'b0;
                    cmp_vld_next    = 1'b0;
                    done_next       = 1'b0;
                    if (item.operation == OP_TICK)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FREE_SCAN;
                    end
                end
            end

            S_FREE_SCAN:
            begin
                if (!valid_reg[cnt_idx])
                begin
                    found_next = 1'b1;
                    slot_next  = cnt_idx;
                    state_next = S_ARR_OUT;
                end
                else if (cnt_reg == CW'(MAX_PROCS - 1))
                begin
                    state_next = S_ARR_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end

            S_ARR_OUT:
            begin
                if (slot_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = found_reg ? ST_ACCEPT : ST_REJECT;
                    out_id_next     = pid_reg;
                    out_fin_next    = now_x[OUT_TIME_W-1:0];
                    out_tat_next    = '0;
                    out_wt_next     = '0;
                    if (found_reg)
                    begin
                        mem_we                = 1'b1;
                        mem_waddr             = slot_reg;
                        mem_wdata             = {pid_reg, now_reg, burst_reg, burst_reg};
                        valid_next[slot_reg]  = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (cmp_vld_reg && rd_better)
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = cmp_idx_reg;
                    best_rem_next   = rd_rem;
                    best_burst_next = rd_burst;
                    best_arr_next   = rd_arr;
                    best_pid_next   = rd_pid;
                end
                if (cnt_reg < CW'(MAX_PROCS))
                begin
                    mem_re       = 1'b1;
                    cmp_vld_next = valid_reg[cnt_idx];
                    cmp_idx_next = cnt_idx;
                    cnt_next     = cnt_reg + CW'(1);
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                    state_next   = S_TICK_UPD;
                end
            end

            S_TICK_UPD:
            begin
                now_next = now_reg + TIME_BITS'(1);
                if (best_found_reg)
                begin
                    if (best_rem_reg <= BURST_W'(1))
                    begin
                        done_next                = 1'b1;
                        valid_next[best_idx_reg] = 1'b0;
                        tat_next = now_reg + TIME_BITS'(1) - best_arr_reg;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                end
                state_next = S_TICK_OUT;
            end

            S_TICK_OUT:
            begin
                if (slot_free)
                begin
                    out_load     = 1'b1;
                    out_fin_next = now_x[OUT_TIME_W-1:0];
                    out_id_next  = best_found_reg ? best_pid_reg : '0;
                    out_tat_next = done_reg ? tat_x[OUT_TIME_W-1:0] : '0;
                    out_wt_next  = done_reg ? wt_x[OUT_TIME_W-1:0] : '0;
                    if (!best_found_reg)
                    begin
                        out_status_next = ST_IDLE;
                    end
                    else if (done_reg)
                    begin
                        out_status_next = ST_DONE;
                    end
                    else
                    begin
                        out_status_next = ST_RAN;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            best_found_reg <= 1'b0;
            done_reg       <= 1'b0;
            now_reg        <= '0;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            found_reg      <= found_next;
            cmp_vld_reg    <= cmp_vld_next;
            best_found_reg <= best_found_next;
            done_reg       <= done_next;
            now_reg        <= now_next;
            valid_reg      <= valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pid_reg        <= pid_next;
        burst_reg      <= burst_next;
        slot_reg       <= slot_next;
        cmp_idx_reg    <= cmp_idx_next;
        best_idx_reg   <= best_idx_next;
        best_rem_reg   <= best_rem_next;
        best_burst_reg <= best_burst_next;
        best_arr_reg   <= best_arr_next;
        best_pid_reg   <= best_pid_next;
        tat_reg        <= tat_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_fin_reg    <= out_fin_next;
        out_tat_reg    <= out_tat_next;
        out_wt_reg     <= out_wt_next;
    end

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || result.ready))
        else $error("result overwritten while stalled");

    // time only advances on the tick update
    a_time_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_TICK_UPD) |=> $stable(now_reg))
        else $error("time changed outside tick update");

    // at most one table slot is claimed or freed per cycle
    a_valid_step: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg ^ $past(valid_reg)) <= 1)
        else $error("multiple slots changed in one cycle");

    // table writes never overlap the scan
    a_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_ARR_OUT || state_reg == S_TICK_UPD))
        else $error("table write during scan");

endmodule

`default_nettype wire
